// File: src/lasm_pkg.sv
package lasm_pkg;

    localparam int MAX_LINE_CHARS_DEF = 100;

    localparam int CHAR_W  = 8;
    localparam int MNEM_W  = 24;
    localparam int MAG_W   = 11;
    localparam int VAL_W   = 12;
    localparam int OP_W    = 4;
    localparam int MODE_W  = 2;
    localparam int WORD_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W  = 15;

    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_AT    = 8'h40;

    localparam logic [OP_W-1:0] OP_DAT     = 4'd0;
    localparam logic [OP_W-1:0] OP_MOV     = 4'd1;
    localparam logic [OP_W-1:0] OP_ADD     = 4'd2;
    localparam logic [OP_W-1:0] OP_SUB     = 4'd3;
    localparam logic [OP_W-1:0] OP_JMP     = 4'd4;
    localparam logic [OP_W-1:0] OP_JMZ     = 4'd5;
    localparam logic [OP_W-1:0] OP_DJZ     = 4'd6;
    localparam logic [OP_W-1:0] OP_CMP     = 4'd7;
    localparam logic [OP_W-1:0] OP_SPL     = 4'd8;
    localparam logic [OP_W-1:0] OP_UNKNOWN = 4'd15;

    localparam int NUM_OPS = 9;

    localparam logic [MNEM_W-1:0] MNEM_TABLE [NUM_OPS] = '{
        24'h444154, 24'h4D4F56, 24'h414444, 24'h535542, 24'h4A4D50,
        24'h4A4D5A, 24'h444A5A, 24'h434D50, 24'h53504C
    };

    localparam logic [CFG_IDX_W-1:0] CFG_IMM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IND = 2'd2;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        MARK_NONE = 2'd0,
        MARK_HASH = 2'd1,
        MARK_AT   = 2'd2
    } t_mark;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              line_end;
    } t_beat;

    typedef struct packed {
        logic [MODE_W-1:0] imm;
        logic [MODE_W-1:0] rel;
        logic [MODE_W-1:0] ind;
    } t_mode_codes;

    typedef struct packed {
        logic [MNEM_W-1:0] mnem;
        t_phase            phase;
        t_mark             mark;
        logic              neg;
        logic [MAG_W-1:0]  mag;
        t_mark             saved_mark;
        logic [VAL_W-1:0]  saved_val;
        logic              ovf;
    } t_line;

    localparam t_line LINE_CLEAR = '{
        mnem:       '0,
        phase:      PH_FIRST,
        mark:       MARK_NONE,
        neg:        1'b0,
        mag:        '0,
        saved_mark: MARK_NONE,
        saved_val:  '0,
        ovf:        1'b0
    };

    function automatic logic [OP_W-1:0] lookup_opcode(input logic [MNEM_W-1:0] mnem);
        logic [OP_W-1:0] op;
        op = OP_UNKNOWN;
        for (int k = NUM_OPS - 1; k >= 0; k--) begin
            if (MNEM_TABLE[k] == mnem) begin
                op = OP_W'(k);
            end
        end
        return op;
    endfunction

    function automatic logic is_single(input logic [OP_W-1:0] op);
        return (op == OP_DAT) || (op == OP_JMP) || (op == OP_SPL);
    endfunction

endpackage

// File: src/lasm_in_reg.sv
module lasm_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  lasm_pkg::t_beat      i_beat,
    output logic                 o_valid,
    output lasm_pkg::t_beat      o_beat,
    input  logic                 i_advance
);

    logic           r_valid;
    lasm_pkg::t_beat r_beat;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

endmodule

// File: src/lasm_scanner.sv
module lasm_scanner #(
    parameter int MAX_LINE_CHARS = lasm_pkg::MAX_LINE_CHARS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lasm_pkg::t_beat i_beat,
    input  logic            i_advance,
    output lasm_pkg::t_line o_line
);

    localparam int PosW = $clog2(MAX_LINE_CHARS + 1);

    logic [PosW-1:0]            r_pos;
    logic [PosW-1:0]            n_pos;
    lasm_pkg::t_line            r_line;
    lasm_pkg::t_line            n_line;
    logic                       do_close;
    logic                       close_nul;
    logic [lasm_pkg::PROD_W-1:0] prod;
    logic [lasm_pkg::CHAR_W-1:0] c;

    assign c = i_beat.text_char;
    assign prod = lasm_pkg::PROD_W'(r_line.mag) * lasm_pkg::PROD_W'(10)
                + lasm_pkg::PROD_W'(c) - lasm_pkg::PROD_W'(lasm_pkg::CH_ZERO);

    always_comb begin
        n_line    = r_line;
        n_pos     = r_pos;
        do_close  = 1'b0;
        close_nul = 1'b0;
        if (r_pos < PosW'(MAX_LINE_CHARS)) begin
            n_pos = r_pos + PosW'(1);
            if (r_pos < PosW'(3)) begin
                case (r_pos[1:0])
                    2'd0:    n_line.mnem[23:16] = r_line.mnem[23:16] | c;
                    2'd1:    n_line.mnem[15:8]  = r_line.mnem[15:8]  | c;
                    default: n_line.mnem[7:0]   = r_line.mnem[7:0]   | c;
                endcase
            end
            if (c == lasm_pkg::CH_NUL) begin
                do_close  = 1'b1;
                close_nul = 1'b1;
            end else if (r_pos >= PosW'(4) && r_line.phase != lasm_pkg::PH_DONE) begin
                if (c == lasm_pkg::CH_SPACE) begin
                    do_close = 1'b1;
                end else if (c >= lasm_pkg::CH_ZERO && c <= lasm_pkg::CH_NINE) begin
                    if (prod > lasm_pkg::PROD_W'(lasm_pkg::MAG_MAX)) begin
                        n_line.mag = lasm_pkg::MAG_MAX;
                        n_line.ovf = 1'b1;
                    end else begin
                        n_line.mag = prod[lasm_pkg::MAG_W-1:0];
                    end
                end else if (c == lasm_pkg::CH_MINUS) begin
                    n_line.neg = 1'b1;
                end else if (c == lasm_pkg::CH_HASH) begin
                    n_line.mark = lasm_pkg::MARK_HASH;
                end else if (c == lasm_pkg::CH_AT) begin
                    n_line.mark = lasm_pkg::MARK_AT;
                end
            end
        end
        if (do_close) begin
            if (r_line.phase == lasm_pkg::PH_FIRST) begin
                n_line.saved_mark = r_line.mark;
                n_line.saved_val  = {r_line.neg, r_line.mag};
                n_line.mark       = lasm_pkg::MARK_NONE;
                n_line.neg        = 1'b0;
                n_line.mag        = '0;
                if (close_nul || lasm_pkg::is_single(lasm_pkg::lookup_opcode(r_line.mnem))) begin
                    n_line.phase = lasm_pkg::PH_DONE;
                end else begin
                    n_line.phase = lasm_pkg::PH_SECOND;
                end
            end else begin
                n_line.phase = lasm_pkg::PH_DONE;
            end
        end
    end

    assign o_line = n_line;

    // clear all line state after the end-of-line beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= lasm_pkg::LINE_CLEAR;
            r_pos  <= '0;
        end else if (i_advance) begin
            if (i_beat.line_end) begin
                r_line <= lasm_pkg::LINE_CLEAR;
                r_pos  <= '0;
            end else begin
                r_line <= n_line;
                r_pos  <= n_pos;
            end
        end
    end

endmodule

// File: src/lasm_packer.sv
module lasm_packer (
    input  lasm_pkg::t_line         i_line,
    input  lasm_pkg::t_mode_codes   i_codes,
    output logic [lasm_pkg::WORD_W-1:0] o_word,
    output logic                    o_error
);

    function automatic logic [lasm_pkg::MODE_W-1:0] encode_mark(
        input lasm_pkg::t_mark     mark,
        input lasm_pkg::t_mode_codes codes
    );
        logic [lasm_pkg::MODE_W-1:0] code;
        case (mark)
            lasm_pkg::MARK_HASH: code = codes.imm;
            lasm_pkg::MARK_AT:   code = codes.ind;
            default:             code = codes.rel;
        endcase
        return code;
    endfunction

    logic [lasm_pkg::OP_W-1:0]  op;
    lasm_pkg::t_mark            first_mark;
    lasm_pkg::t_mark            second_mark;
    logic [lasm_pkg::VAL_W-1:0] first_val;
    logic [lasm_pkg::VAL_W-1:0] second_val;
    logic [lasm_pkg::VAL_W-1:0] cur_val;

    assign op      = lasm_pkg::lookup_opcode(i_line.mnem);
    assign cur_val = {i_line.neg, i_line.mag};

    always_comb begin
        if (i_line.phase == lasm_pkg::PH_FIRST) begin
            first_mark  = i_line.mark;
            first_val   = cur_val;
            second_mark = lasm_pkg::MARK_NONE;
            second_val  = '0;
        end else begin
            first_mark  = i_line.saved_mark;
            first_val   = i_line.saved_val;
            second_mark = i_line.mark;
            second_val  = cur_val;
        end
    end

    always_comb begin
        if (op == lasm_pkg::OP_UNKNOWN) begin
            o_word  = '0;
            o_error = 1'b1;
        end else if (lasm_pkg::is_single(op)) begin
            o_word  = {op, 2'b00, encode_mark(first_mark, i_codes),
                       {lasm_pkg::VAL_W{1'b0}}, first_val};
            o_error = i_line.ovf;
        end else begin
            o_word  = {op, encode_mark(first_mark, i_codes),
                       encode_mark(second_mark, i_codes), first_val, second_val};
            o_error = i_line.ovf;
        end
    end

endmodule

// File: src/redcode_line_assembler.sv
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------
// in       | i_in_valid / o_in_ready   | i_text_char, i_line_end
// out      | o_out_valid / i_out_ready | o_instruction_word, o_syntax_error
// cfg      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One beat per cycle unless the output stalls; the output word is registered.
// Each beat is parsed by one pass of logic between the input register and the
// line state / output registers (decimal step: multiply by ten, add, saturate).
// Reset (synchronous) clears line state and loads mode codes 0, 1, 2.
// A stalled output blocks only the line-end beat behind it; other beats advance.
module redcode_line_assembler #(
    parameter int MAX_LINE_CHARS = lasm_pkg::MAX_LINE_CHARS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [lasm_pkg::CHAR_W-1:0]       i_text_char,
    input  logic                              i_line_end,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lasm_pkg::WORD_W-1:0]       o_instruction_word,
    output logic                              o_syntax_error,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lasm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lasm_pkg::MODE_W-1:0]       i_cfg_data
);

    lasm_pkg::t_beat            in_beat;
    lasm_pkg::t_beat            q_beat;
    logic                       q_valid;
    logic                       advance;
    lasm_pkg::t_line            line_next;
    logic [lasm_pkg::WORD_W-1:0] word;
    logic                       error;

    lasm_pkg::t_mode_codes      r_codes;
    logic                       r_out_valid;
    logic [lasm_pkg::WORD_W-1:0] r_word;
    logic                       r_error;

    assign in_beat = '{text_char: i_text_char, line_end: i_line_end};
    assign advance = q_valid && (!q_beat.line_end || !r_out_valid || i_out_ready);

    lasm_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_beat    (in_beat),
        .o_valid   (q_valid),
        .o_beat    (q_beat),
        .i_advance (advance)
    );

    lasm_scanner #(
        .MAX_LINE_CHARS (MAX_LINE_CHARS)
    ) u_scanner (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (q_beat),
        .i_advance (advance),
        .o_line    (line_next)
    );

    lasm_packer u_packer (
        .i_line  (line_next),
        .i_codes (r_codes),
        .o_word  (word),
        .o_error (error)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes <= '{imm: 2'd0, rel: 2'd1, ind: 2'd2};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lasm_pkg::CFG_IMM: r_codes.imm <= i_cfg_data;
                lasm_pkg::CFG_REL: r_codes.rel <= i_cfg_data;
                lasm_pkg::CFG_IND: r_codes.ind <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && q_beat.line_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && q_beat.line_end) begin
            r_word  <= word;
            r_error <= error;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_instruction_word = r_word;
    assign o_syntax_error     = r_error;

endmodule
